// File: rtl/ksa_pkg.sv
// Shared types and constants for the ascending key sorter.
package ksa_pkg;

   localparam int KEY_W = 64;

   typedef logic [KEY_W-1:0] key_type;

   // Sequencer states: collecting keys, or draining the sorted chain.
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Command broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic    insert;
      logic    shift;
      key_type key;
   } cmd_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic    valid;
      logic    gt;
      key_type key;
   } link_type;

endpackage

// File: rtl/ksa_cell.sv
// One cell of the sorting chain: holds one key and trades it with its neighbors.
module ksa_cell
   import ksa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type left_link,
   input  link_type right_link,
   output link_type own_link
);

   logic    valid_ff, valid_in;
   key_type key_ff, key_in;
   logic    gt;
   logic    take;

   assign gt   = valid_ff && (key_ff > cmd.key);
   assign take = gt || !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (cmd.shift) begin
         valid_in = right_link.valid;
         key_in   = right_link.key;
      end else if (cmd.insert && take) begin
         // The left neighbor's larger key moves in, or the new key lands here.
         if (left_link.gt) begin
            valid_in = 1'b1;
            key_in   = left_link.key;
         end else if (left_link.valid) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign own_link = '{valid: valid_ff, gt: gt, key: key_ff};

endmodule

// File: rtl/key_sorter_ascending_top.sv
// Top level of the ascending key sorter: cell chain, sequencer and output register.
// Keys are accepted while loading; the key with tlast set ends the batch. Draining
// starts the next cycle and delivers one key per cycle while rsp_tready is high.
// The next batch is accepted once the final key has left the chain.
// Synchronous active-high reset empties the chain and clears all control state.
module key_sorter_ascending_top
   import ksa_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [KEY_W-1:0] req_tdata,  // [63:0] key
   input  logic             req_tlast,  // is_last
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [KEY_W-1:0] rsp_tdata,  // [63:0] sorted_key
   output logic             rsp_tlast,  // last_out
   output logic             rsp_tuser   // [0] overflow
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // Sequencer and batch bookkeeping.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   // Output register; it parts the chain from the result channel.
   logic    out_valid_ff, out_valid_in;
   key_type out_key_ff, out_key_in;
   logic    out_last_ff, out_last_in;
   logic    out_ovf_ff, out_ovf_in;

   cmd_type  cmd;
   link_type links [DEPTH];

   logic req_xfer;
   logic pop;
   logic has_room;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign has_room   = (count_ff < CNT_W'(DEPTH));

   // While draining, a key leaves the chain when the output register is free or being emptied.
   assign pop = (state_ff == ST_DRAIN) && (!out_valid_ff || rsp_tready);

   // Every cell sees the same command: insert the arriving key, or shift left.
   assign cmd.insert = req_xfer && has_room;
   assign cmd.shift  = pop;
   assign cmd.key    = req_tdata;

   // The chain: each cell keeps the chain sorted with its neighbors' help.
   // Cell 0 sees a left neighbor that is always valid and never greater, and
   // the last cell sees an empty right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left_l;
      link_type right_l;

      if (i == 0) begin : g_first
         assign left_l = '{valid: 1'b1, gt: 1'b0, key: '0};
      end else begin : g_mid_left
         assign left_l = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
         assign right_l = '{valid: 1'b0, gt: 1'b0, key: '0};
      end else begin : g_mid_right
         assign right_l = links[i+1];
      end

      ksa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_l),
         .right_link (right_l),
         .own_link   (links[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               // A full chain drops the key but remembers the loss for the batch.
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               out_valid_in = 1'b1;
               out_key_in   = links[0].key;
               out_last_in  = !links[1].valid;
               out_ovf_in   = dropped_ff;
               if (!links[1].valid) begin
                  // The greatest key is leaving: open the next batch.
                  state_in   = ST_LOAD;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_key_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

// File: verif/key_sorter_ascending_top_tb.sv
// Self-checking testbench for the ascending key sorter: directed table, then random batches.
module key_sorter_ascending_top_tb
   import ksa_pkg::*;
;

   // Capacity of the instance; the default of the block is kept.
   localparam int DEPTH = 64;
   // Cycles to wait after the last expected key so that a stray extra transfer is caught.
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   // Number of random input transfers, and the point from which no idling is applied.
   localparam int RANDOM_ITEMS = 230;
   localparam int QUIET_FROM = 190;
   localparam int MAX_REPORTS = 10;
   localparam key_type ALL_ONES = {KEY_W{1'b1}};
   localparam key_type TOP_BIT = {1'b1, {(KEY_W-1){1'b0}}};

   // One key as the sorter should deliver it.
   typedef struct packed {
      key_type key;
      logic    last;
      logic    ovf;
   } sorted_entry_type;

   // One row of the directed table. Rows with typed set are single-key batches
   // whose result is written down here instead of being predicted.
   typedef struct packed {
      key_type key;
      logic    last;
      logic    typed;
      key_type exp_key;
      logic    exp_ovf;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_tvalid;
   logic    req_tready;
   key_type req_tdata;
   logic    req_tlast;
   logic    rsp_tvalid;
   logic    rsp_tready;
   key_type rsp_tdata;
   logic    rsp_tlast;
   logic    rsp_tuser;

   // Predictor state: the keys held for the open batch and whether any was dropped.
   key_type          batch_keys[$];
   logic             batch_dropped;
   // Keys still owed by the sorter, oldest first.
   sorted_entry_type expected_sorted[$];
   sorted_entry_type want_entry;

   int   mismatches;
   bit   idle_on;
   int   rsp_stall_left;
   int   random_sent;
   stim_row_type dir_rows[22];

   key_sorter_ascending_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is cut off well past the slowest legal finish.
   initial begin
      #200000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Takes one accepted key into the predicted batch. A key that finds the store
   // full is dropped and marks the batch. When the key closes the batch, the held
   // keys are sorted and queued as expected transfers, unless the caller has
   // already queued a typed expectation for this batch.
   function automatic void absorb_key(key_type key, logic closes, bit predict);
      key_type          held;
      int               j;
      sorted_entry_type entry;
      if (batch_keys.size() < DEPTH) begin
         batch_keys.push_back(key);
      end else begin
         batch_dropped = 1'b1;
      end
      if (!closes) return;
      // Insertion sort, smallest key first; equal keys are interchangeable.
      for (int i = 1; i < batch_keys.size(); i++) begin
         held = batch_keys[i];
         j = i;
         while (j > 0 && batch_keys[j-1] > held) begin
            batch_keys[j] = batch_keys[j-1];
            j--;
         end
         batch_keys[j] = held;
      end
      if (predict) begin
         for (int k = 0; k < batch_keys.size(); k++) begin
            entry.key  = batch_keys[k];
            entry.last = (k == batch_keys.size() - 1);
            entry.ovf  = batch_dropped;
            expected_sorted.push_back(entry);
         end
      end
      batch_keys.delete();
      batch_dropped = 1'b0;
   endfunction

   // Random key: mostly full-width, with extremes and a small pool that makes
   // equal keys common inside a batch.
   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2, 3: return key_type'($urandom_range(0, 3));
         4: return {32'hFFFF_FFFF, 30'd0, 2'($urandom_range(0, 3))};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one key on the request side, with an occasional idle burst first, and
   // returns at the falling edge after the transfer. The predictor sees the key at
   // the edge where the transfer happens.
   task automatic send_key(key_type key, logic closes, bit predict);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tlast  <= closes;
      do @(posedge clock); while (!req_tready);
      absorb_key(key, closes, predict);
      @(negedge clock);
   endtask

   task automatic send_batch(int len);
      for (int i = 0; i < len; i++) begin
         send_key(pick_key(), i == len - 1, 1'b1);
         random_sent++;
         if (random_sent >= QUIET_FROM) idle_on = 1'b0;
      end
   endtask

   // The result side stalls in random bursts while idling is on.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall_left = $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result transfer is matched against the oldest key still expected.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sorted.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: key %h last %b ovf %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want_entry = expected_sorted.pop_front();
            if (rsp_tdata !== want_entry.key || rsp_tlast !== want_entry.last ||
                rsp_tuser !== want_entry.ovf) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected key %h last %b ovf %b, got key %h last %b ovf %b",
                           want_entry.key, want_entry.last, want_entry.ovf,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   initial begin
      sorted_entry_type typed_entry;
      int len;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      rsp_stall_left = 0;
      mismatches     = 0;
      random_sent    = 0;
      batch_dropped  = 1'b0;
      idle_on        = 1'b1;

      // Single-key batches come first; their one result is the key itself, flagged
      // as the last of its batch and without overflow. The multi-key batches cover
      // reversed order, already sorted order, equal keys and both extremes mixed.
      dir_rows = '{
         '{'0,                    1'b1, 1'b1, '0,        1'b0},
         '{ALL_ONES,              1'b1, 1'b1, ALL_ONES,  1'b0},
         '{TOP_BIT,               1'b1, 1'b1, TOP_BIT,   1'b0},
         '{key_type'(1),          1'b1, 1'b1, key_type'(1), 1'b0},
         '{ALL_ONES,              1'b0, 1'b0, '0,        1'b0},
         '{'0,                    1'b0, 1'b0, '0,        1'b0},
         '{key_type'(5),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(5),          1'b0, 1'b0, '0,        1'b0},
         '{TOP_BIT,               1'b1, 1'b0, '0,        1'b0},
         '{key_type'(2),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(1),          1'b1, 1'b0, '0,        1'b0},
         '{key_type'(7),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(7),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(7),          1'b1, 1'b0, '0,        1'b0},
         '{key_type'(1),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(2),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(3),          1'b0, 1'b0, '0,        1'b0},
         '{key_type'(4),          1'b1, 1'b0, '0,        1'b0},
         '{{32{2'b01}},           1'b0, 1'b0, '0,        1'b0},
         '{{32{2'b10}},           1'b0, 1'b0, '0,        1'b0},
         '{'0,                    1'b0, 1'b0, '0,        1'b0},
         '{ALL_ONES,              1'b1, 1'b0, '0,        1'b0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows queue their written-down result before the key
      // is offered, so it is in place long before the sorter can answer.
      foreach (dir_rows[r]) begin
         if (dir_rows[r].typed) begin
            typed_entry.key  = dir_rows[r].exp_key;
            typed_entry.last = 1'b1;
            typed_entry.ovf  = dir_rows[r].exp_ovf;
            expected_sorted.push_back(typed_entry);
         end
         send_key(dir_rows[r].key, dir_rows[r].last, !dir_rows[r].typed);
      end

      // Hold the request side off until the sorter has delivered every key owed.
      req_tvalid <= 1'b0;
      while (expected_sorted.size() != 0) @(negedge clock);

      // A batch that fills the store exactly, then one that overflows it. In the
      // second one the key that closes the batch is itself dropped, and every
      // result must carry the overflow flag.
      send_batch(DEPTH);
      send_batch(DEPTH + 2);

      // Short random batches make up the rest, with an occasional mid-size one.
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) len = $urandom_range(9, 24);
         else len = $urandom_range(1, 8);
         send_batch(len);
      end
      req_tvalid <= 1'b0;

      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_sorted.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
